// File: hw/rtl/mlp_forward_inference_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the forward-pass network block.
// Short forms of the concurrent assertions used in the sequencer.
// ----------------------------------------------------------------------------
`ifndef MLP_FORWARD_INFERENCE_TOP_MACROS_SVH
`define MLP_FORWARD_INFERENCE_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MLPF_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("mlpf: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define MLPF_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("mlpf: next-cycle check failed");

`endif

// File: hw/rtl/mlpf_pkg.sv
// ----------------------------------------------------------------------------
// mlpf_pkg
// Types, codes, defaults and the sigmoid sample function of the network block.
// ----------------------------------------------------------------------------
package mlpf_pkg;

  // Default sizes of the storage.
  localparam int MAX_LAYERS_DEF      = 4;
  localparam int MAX_NEURONS_DEF     = 16;
  localparam int SIGMOID_ENTRIES_DEF = 256;

  // One in Q8.8.
  localparam logic [15:0] ONE_Q88 = 16'd256;

  // Per-step decay factor of e^-x in Q32, one step being 1/256.
  localparam logic [63:0] EXP_STEP_Q32 = 64'd4278222805;

  // Register reset values.
  localparam logic [2:0] LAYER_COUNT_RST = 3'd3;
  localparam logic [4:0] LAYER0_RST      = 5'd4;
  localparam logic [4:0] LAYER1_RST      = 5'd4;
  localparam logic [4:0] LAYER2_RST      = 5'd1;
  localparam logic [4:0] LAYER3_RST      = 5'd1;
  localparam logic       ACT_MODE_RST    = 1'b1;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_LAYER_COUNT = 3'd0,
    REG_LAYER0_SIZE = 3'd1,
    REG_LAYER1_SIZE = 3'd2,
    REG_LAYER2_SIZE = 3'd3,
    REG_LAYER3_SIZE = 3'd4,
    REG_ACT_MODE    = 3'd5
  } cfg_reg_t;

  // Request operation codes.
  localparam logic OP_WEIGHT  = 1'b0;
  localparam logic OP_FEATURE = 1'b1;

  // One input request.
  typedef struct packed {
    logic        op;
    logic [1:0]  weight_layer;
    logic [4:0]  weight_from;
    logic [3:0]  weight_to;
    logic [15:0] weight_value;
    logic [3:0]  feature_index;
    logic [15:0] feature_value;
    logic        last_feature;
  } in_item_t;

  // One result.
  typedef struct packed {
    logic [3:0] output_index;
    logic [8:0] output_value;
    logic       last_output;
  } out_item_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_MUL,
    S_ACC,
    S_RND,
    S_WR,
    S_ORD,
    S_OUT
  } seq_state_t;

  // Control from the sequencer to the datapath.
  typedef struct packed {
    logic rd_pass;
    logic mul_en;
    logic acc_en;
    logic acc_clr;
    logic sig_en;
    logic act_wr;
    logic rd_out;
    logic out_valid;
    logic out_last;
    logic clr_feat;
  } seq_ctrl_t;

  // Saturate an integer to a range.
  function automatic int clamp_int(input int v, input int lo, input int hi);
    int r;
    r = v;
    if (v < lo) r = lo;
    if (v > hi) r = hi;
    return r;
  endfunction

  // Sigmoid sample i of a table of 2**sb entries, worked out at elaboration.
  function automatic logic [8:0] sig_entry(input int i, input int sb);
    logic [63:0] e;
    logic [63:0] d;
    logic [63:0] num;
    logic [8:0]  q;
    logic        neg;
    int          k;
    int          m;
    k   = i - (1 << (sb - 1));
    neg = (k < 0);
    if (neg) k = -k;
    m = (k << 12) >> sb;
    e = 64'd1 << 32;
    for (int j = 0; j < 2048; j++) begin
      if (j < m) e = (e * EXP_STEP_Q32 + (64'd1 << 31)) >> 32;
    end
    d   = (64'd1 << 32) + e;
    num = neg ? ((e << 9) + d) : ((64'd1 << 41) + d);
    q   = '0;
    // Restoring division by twice d, one quotient bit a step.
    for (int b = 8; b >= 0; b--) begin
      if (num >= (d << (b + 1))) begin
        num  = num - (d << (b + 1));
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

endpackage

// File: hw/rtl/mlpf_mac.sv
// ----------------------------------------------------------------------------
// mlpf_mac
// Shared multiply-accumulate unit with Q8.8 rounding and saturation.
// ----------------------------------------------------------------------------
module mlpf_mac #(
  parameter int MAX_NEURONS = mlpf_pkg::MAX_NEURONS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  mlpf_pkg::seq_ctrl_t ctrl,
  input  logic signed [15:0]  act,
  input  logic signed [15:0]  wgt,
  output logic signed [15:0]  sum
);
  import mlpf_pkg::*;

  localparam int ACCW = 33 + $clog2(MAX_NEURONS + 1);

  logic signed [31:0]   prod_r;
  logic signed [ACCW-1:0] acc_r;
  logic signed [ACCW-1:0] acc_rnd;
  logic signed [ACCW-1:0] acc_shr;

  // Product register between multiplier and adder.
  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod_r <= act * wgt;
    end
  end

  // Exact accumulator.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (ctrl.acc_clr) begin
      acc_r <= '0;
    end else if (ctrl.acc_en) begin
      acc_r <= acc_r + ACCW'(prod_r);
    end
  end

  // Round to nearest Q8.8 with ties upwards, then saturate to 16 bits.
  always_comb begin
    acc_rnd = acc_r + ACCW'(2048);
    acc_shr = acc_rnd >>> 12;
    if (acc_shr > ACCW'(32767)) begin
      sum = 16'sh7FFF;
    end else if (acc_shr < -ACCW'(32768)) begin
      sum = -16'sh8000;
    end else begin
      sum = acc_shr[15:0];
    end
  end

endmodule

// File: hw/rtl/mlpf_sig.sv
// ----------------------------------------------------------------------------
// mlpf_sig
// Sigmoid lookup with a registered read and the activation mode select.
// ----------------------------------------------------------------------------
module mlpf_sig #(
  parameter int SIGMOID_ENTRIES = mlpf_pkg::SIGMOID_ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               en,
  input  logic               mode,
  input  logic signed [15:0] sum,
  output logic [8:0]         act_r
);
  import mlpf_pkg::*;

  localparam int SB = $clog2(SIGMOID_ENTRIES);

  logic [8:0]    rom [SIGMOID_ENTRIES];
  logic [11:0]   pos;
  logic [SB-1:0] idx;

  // Table samples, fixed at elaboration.
  for (genvar gi = 0; gi < SIGMOID_ENTRIES; gi++) begin : g_rom
    assign rom[gi] = sig_entry(gi, SB);
  end

  // Clamp to minus eight .. just under eight and scale to a table index.
  always_comb begin
    if (sum < -16'sd2048) begin
      pos = 12'd0;
    end else if (sum > 16'sd2047) begin
      pos = 12'd4095;
    end else begin
      pos = 12'(sum + 16'sd2048);
    end
    idx = SB'(pos >> (12 - SB));
  end

  // Registered read; mode zero forces a zero activation.
  always_ff @(posedge clk) begin
    if (en) begin
      act_r <= mode ? rom[idx] : 9'd0;
    end
  end

endmodule

// File: hw/rtl/mlpf_seq.sv
// ----------------------------------------------------------------------------
// mlpf_seq
// Sequencer that walks layers, neurons and inputs for the shared MAC unit.
// ----------------------------------------------------------------------------
`include "mlp_forward_inference_top_macros.svh"

module mlpf_seq #(
  parameter int MAX_LAYERS  = mlpf_pkg::MAX_LAYERS_DEF,
  parameter int MAX_NEURONS = mlpf_pkg::MAX_NEURONS_DEF,
  localparam int NW  = $clog2(MAX_NEURONS + 1),
  localparam int LW  = $clog2(MAX_LAYERS),
  localparam int LCW = $clog2(MAX_LAYERS + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                go,
  input  logic [LCW-1:0]      layers,
  input  logic [NW-1:0]       size_prev,
  input  logic [NW-1:0]       size_cur,
  input  logic [NW-1:0]       size_last,
  output mlpf_pkg::seq_ctrl_t ctrl,
  output logic [LW-1:0]       l_r,
  output logic [NW-1:0]       n_r,
  output logic [NW-1:0]       j_r,
  output logic                busy
);
  import mlpf_pkg::*;

  seq_state_t    state_r, state_nxt;
  logic [LW-1:0] l_nxt;
  logic [NW-1:0] n_nxt;
  logic [NW-1:0] j_nxt;
  logic          last_layer;

  assign last_layer = (LCW'(l_r) == layers - LCW'(1));

  // State and counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      l_r     <= '0;
      n_r     <= '0;
      j_r     <= '0;
    end else begin
      state_r <= state_nxt;
      l_r     <= l_nxt;
      n_r     <= n_nxt;
      j_r     <= j_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    l_nxt     = l_r;
    n_nxt     = n_r;
    j_nxt     = j_r;
    case (state_r)
      S_IDLE: begin
        if (go) begin
          state_nxt = S_RD;
          l_nxt     = LW'(1);
          n_nxt     = NW'(1);
          j_nxt     = '0;
        end
      end
      S_RD:  state_nxt = S_MUL;
      S_MUL: state_nxt = S_ACC;
      S_ACC: begin
        if (j_r == size_prev) begin
          state_nxt = S_RND;
        end else begin
          j_nxt     = j_r + NW'(1);
          state_nxt = S_RD;
        end
      end
      S_RND: state_nxt = S_WR;
      S_WR: begin
        j_nxt = '0;
        if (n_r == size_cur) begin
          n_nxt = NW'(1);
          if (last_layer) begin
            state_nxt = S_ORD;
          end else begin
            l_nxt     = l_r + LW'(1);
            state_nxt = S_RD;
          end
        end else begin
          n_nxt     = n_r + NW'(1);
          state_nxt = S_RD;
        end
      end
      S_ORD: state_nxt = S_OUT;
      S_OUT: begin
        if (n_r == size_last) begin
          state_nxt = S_IDLE;
        end else begin
          n_nxt     = n_r + NW'(1);
          state_nxt = S_ORD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    ctrl           = '0;
    ctrl.rd_pass   = (state_r == S_RD);
    ctrl.mul_en    = (state_r == S_MUL);
    ctrl.acc_en    = (state_r == S_ACC);
    ctrl.acc_clr   = (state_r == S_WR) || (state_r == S_IDLE);
    ctrl.sig_en    = (state_r == S_RND);
    ctrl.act_wr    = (state_r == S_WR);
    ctrl.rd_out    = (state_r == S_ORD);
    ctrl.out_valid = (state_r == S_OUT);
    ctrl.out_last  = (state_r == S_OUT) && (n_r == size_last);
    ctrl.clr_feat  = ctrl.out_last;
  end

  assign busy = (state_r != S_IDLE);

  // Checks.
  `MLPF_ASSERT_NXT(a_go_starts, clk, rst_n, go && !busy, state_r == S_RD && l_r == LW'(1))
  `MLPF_ASSERT_NXT(a_last_idles, clk, rst_n, ctrl.out_last, state_r == S_IDLE)
  `MLPF_ASSERT_NXT(a_sum_done, clk, rst_n, state_r == S_ACC && j_r == size_prev,
                   state_r == S_RND)
  `MLPF_ASSERT_IMP(a_out_index, clk, rst_n, ctrl.out_valid, n_r != '0 && n_r <= size_last)

endmodule

// File: hw/rtl/mlp_forward_inference_top.sv
// ----------------------------------------------------------------------------
// mlp_forward_inference_top
// Fully connected network inference with a table sigmoid.
// ----------------------------------------------------------------------------
// Use: a request is taken at a clock edge with start high and busy low.
// A weight request (op 0) writes one Q4.12 weight. A feature
// request (op 1) writes one Q8.8 input; with last_feature set it starts the
// forward pass and busy stays high until the last result has gone out.
// Each connection, the bias included, goes through read, multiply and add
// steps of the shared multiply-accumulate unit, each neuron then through a
// round with table read and a write back, and each result through an
// output read and its strobe. The default 4-4-1 network gives a single
// result. Results appear on out_item with out_valid high for exactly one
// cycle each, in neuron order, the final one marked by last_output; the
// receiver cannot hold them off. Configuration is written through
// cfg_we, cfg_index and cfg_wdata; the user must write it only while
// busy is low, which the block itself does not enforce. Reset restores
// the register defaults and clears the input layer; weights stay
// undefined until written. After each pass the input layer reads as zero
// again.
// ----------------------------------------------------------------------------
module mlp_forward_inference_top #(
  parameter int MAX_LAYERS      = mlpf_pkg::MAX_LAYERS_DEF,
  parameter int MAX_NEURONS     = mlpf_pkg::MAX_NEURONS_DEF,
  parameter int SIGMOID_ENTRIES = mlpf_pkg::SIGMOID_ENTRIES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  mlpf_pkg::in_item_t  in_item,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [4:0]          cfg_wdata,
  output logic                out_valid,
  output mlpf_pkg::out_item_t out_item
);
  import mlpf_pkg::*;

  localparam int NODES  = MAX_NEURONS + 1;
  localparam int NW     = $clog2(NODES);
  localparam int LW     = $clog2(MAX_LAYERS);
  localparam int LCW    = $clog2(MAX_LAYERS + 1);
  localparam int WDEPTH = (MAX_LAYERS - 1) * NODES * MAX_NEURONS;
  localparam int WAW    = $clog2(WDEPTH);
  localparam int ADEPTH = MAX_LAYERS * NODES;
  localparam int AAW    = $clog2(ADEPTH);

  // Configuration registers.
  logic [2:0] lcnt_r;
  logic [4:0] lsz_r [4];
  logic       mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lcnt_r   <= LAYER_COUNT_RST;
      lsz_r[0] <= LAYER0_RST;
      lsz_r[1] <= LAYER1_RST;
      lsz_r[2] <= LAYER2_RST;
      lsz_r[3] <= LAYER3_RST;
      mode_r   <= ACT_MODE_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_LAYER_COUNT: lcnt_r   <= cfg_wdata[2:0];
        REG_LAYER0_SIZE: lsz_r[0] <= cfg_wdata;
        REG_LAYER1_SIZE: lsz_r[1] <= cfg_wdata;
        REG_LAYER2_SIZE: lsz_r[2] <= cfg_wdata;
        REG_LAYER3_SIZE: lsz_r[3] <= cfg_wdata;
        REG_ACT_MODE:    mode_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Effective layer count and sizes, saturated into range.
  logic [LCW-1:0] layers;
  logic [NW-1:0]  sz [MAX_LAYERS];

  assign layers = LCW'(clamp_int(int'(lcnt_r), 2, MAX_LAYERS));

  for (genvar gi = 0; gi < MAX_LAYERS; gi++) begin : g_size
    if (gi < 4) begin : g_reg
      assign sz[gi] = NW'(clamp_int(int'(lsz_r[gi]), 1, MAX_NEURONS));
    end else begin : g_one
      assign sz[gi] = NW'(1);
    end
  end

  // Sequencer.
  seq_ctrl_t     ctrl;
  logic [LW-1:0] l_r;
  logic [NW-1:0] n_r;
  logic [NW-1:0] j_r;
  logic          accept;
  logic          go;

  assign accept = start && !busy;
  assign go     = accept && (in_item.op == OP_FEATURE) && in_item.last_feature;

  mlpf_seq #(
    .MAX_LAYERS  (MAX_LAYERS),
    .MAX_NEURONS (MAX_NEURONS)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (go),
    .layers    (layers),
    .size_prev (sz[l_r - LW'(1)]),
    .size_cur  (sz[l_r]),
    .size_last (sz[LW'(layers - LCW'(1))]),
    .ctrl      (ctrl),
    .l_r       (l_r),
    .n_r       (n_r),
    .j_r       (j_r),
    .busy      (busy)
  );

  // Weight store: one write port for loading, one registered read for the pass.
  logic [15:0]    wmem [WDEPTH];
  logic [15:0]    w_rd_r;
  logic           w_we;
  logic [WAW-1:0] w_waddr;
  logic [WAW-1:0] w_raddr;

  assign w_we = accept && (in_item.op == OP_WEIGHT)
             && (int'(in_item.weight_layer) < MAX_LAYERS - 1)
             && (int'(in_item.weight_from) <= MAX_NEURONS)
             && (int'(in_item.weight_to) < MAX_NEURONS);
  assign w_waddr = WAW'((int'(in_item.weight_layer) * NODES + int'(in_item.weight_from))
                        * MAX_NEURONS + int'(in_item.weight_to));
  assign w_raddr = WAW'(((int'(l_r) - 1) * NODES + int'(j_r)) * MAX_NEURONS
                        + int'(n_r) - 1);

  always_ff @(posedge clk) begin
    if (w_we) begin
      wmem[w_waddr] <= in_item.weight_value;
    end
    if (ctrl.rd_pass) begin
      w_rd_r <= wmem[w_raddr];
    end
  end

  // Activation store; bias nodes are never stored and read as one.
  logic [15:0]    amem [ADEPTH];
  logic [15:0]    a_rd_r;
  logic           a_bias_r;
  logic           a_zero_r;
  logic [NODES-1:0] fvalid_r;
  logic           f_we;
  logic [4:0]     f_node;
  logic           a_we;
  logic [AAW-1:0] a_waddr;
  logic [15:0]    a_wdata;
  logic [AAW-1:0] a_raddr;
  logic [8:0]     sig_r;

  assign f_node = 5'(in_item.feature_index) + 5'd1;
  assign f_we   = accept && (in_item.op == OP_FEATURE)
               && (int'(in_item.feature_index) < int'(sz[0]));

  always_comb begin
    if (ctrl.act_wr) begin
      a_we    = 1'b1;
      a_waddr = AAW'(int'(l_r) * NODES + int'(n_r));
      a_wdata = {7'd0, sig_r};
    end else begin
      a_we    = f_we;
      a_waddr = AAW'(f_node);
      a_wdata = in_item.feature_value;
    end
    if (ctrl.rd_out) begin
      a_raddr = AAW'((int'(layers) - 1) * NODES + int'(n_r));
    end else begin
      a_raddr = AAW'((int'(l_r) - 1) * NODES + int'(j_r));
    end
  end

  always_ff @(posedge clk) begin
    if (a_we) begin
      amem[a_waddr] <= a_wdata;
    end
    if (ctrl.rd_pass || ctrl.rd_out) begin
      a_rd_r <= amem[a_raddr];
    end
  end

  // Source flags that travel with the read: bias node, or unwritten feature.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_bias_r <= 1'b0;
      a_zero_r <= 1'b0;
    end else if (ctrl.rd_pass) begin
      a_bias_r <= (j_r == '0);
      a_zero_r <= (l_r == LW'(1)) && !fvalid_r[j_r];
    end else if (ctrl.rd_out) begin
      a_bias_r <= 1'b0;
      a_zero_r <= 1'b0;
    end
  end

  // Input-layer valid bits, cleared at reset and after each pass.
  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.clr_feat) begin
      fvalid_r <= '0;
    end else if (f_we) begin
      fvalid_r[NW'(f_node)] <= 1'b1;
    end
  end

  // Shared arithmetic.
  logic signed [15:0] act_eff;
  logic signed [15:0] sum;

  assign act_eff = a_bias_r ? ONE_Q88 : (a_zero_r ? 16'd0 : a_rd_r);

  mlpf_mac #(
    .MAX_NEURONS (MAX_NEURONS)
  ) u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (ctrl),
    .act   (act_eff),
    .wgt   (w_rd_r),
    .sum   (sum)
  );

  mlpf_sig #(
    .SIGMOID_ENTRIES (SIGMOID_ENTRIES)
  ) u_sig (
    .clk   (clk),
    .en    (ctrl.sig_en),
    .mode  (mode_r),
    .sum   (sum),
    .act_r (sig_r)
  );

  // Results.
  assign out_valid             = ctrl.out_valid;
  assign out_item.output_index = 4'(n_r - NW'(1));
  assign out_item.output_value = a_rd_r[8:0];
  assign out_item.last_output  = ctrl.out_last;

endmodule

// File: verif/tb_mlp_forward_inference_top.sv
// ----------------------------------------------------------------------------
// Testbench for the forward-pass network block
// Loads weights and features, runs forward passes under several network
// shapes and both activation modes, and checks every result against a
// behavioural predictor of the network held in the testbench.
// ----------------------------------------------------------------------------
module tb_mlp_forward_inference_top;
  import mlpf_pkg::*;

  localparam int NL = 4;
  localparam int NN = 16;
  localparam int ND = NN + 1;
  localparam int SE = 256;
  // Largest hidden and output layer used by the random part.
  localparam int HN = 4;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_item_t  in_item = '0;
  logic      cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [4:0] cfg_wdata = '0;
  logic      out_valid;
  out_item_t out_item;

  mlp_forward_inference_top dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .out_valid(out_valid), .out_item(out_item)
  );

  always #6 clk = ~clk;

  // Predictor state: the network as the block should hold it.
  logic [15:0] weights [NL-1][ND][NN];
  logic [15:0] acts [NL][ND];
  logic [8:0]  sig_lut [SE];
  logic [4:0]  regs [6];
  out_item_t   expected_results [$];
  int          errors = 0;

  task automatic report(input string what, input out_item_t got, input out_item_t exp);
    $display("error %s: got idx %0d val %0d last %0b, expected idx %0d val %0d last %0b",
             what, got.output_index, got.output_value, got.last_output,
             exp.output_index, exp.output_value, exp.last_output);
    errors++;
  endtask

  // Sigmoid table: walk e^-x down in Q32 and sample it.
  function automatic logic [8:0] sig_sample(input logic [63:0] e, input bit neg);
    logic [63:0] d, a2;
    d  = (64'd1 << 32) + e;
    a2 = neg ? 64'd512 * e : (64'd1 << 41);
    return 9'((a2 + d) / (2 * d));
  endfunction

  task automatic build_sigmoid();
    logic [63:0] e;
    int k;
    e = 64'd1 << 32;
    for (int m = 0; m <= 2048; m++) begin
      if (m % (4096 / SE) == 0) begin
        k = m / (4096 / SE);
        if (SE / 2 + k < SE) sig_lut[SE/2 + k] = sig_sample(e, 1'b0);
        if (k > 0 && k <= SE / 2) sig_lut[SE/2 - k] = sig_sample(e, 1'b1);
      end
      e = (e * 64'd4278222805 + (64'd1 << 31)) >> 32;
    end
  endtask

  function automatic int sat(input int v, input int lo, input int hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic logic [15:0] activation(input longint acc);
    longint r;
    int c;
    r = (acc + 2048) >>> 12;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    if (regs[REG_ACT_MODE][0] == 1'b0) return 16'd0;
    c = sat(int'(r), -2048, 2047);
    return {7'd0, sig_lut[(c + 2048) * SE / 4096]};
  endfunction

  // Apply one request to the network model and queue the results it causes.
  task automatic predict_network(input in_item_t it);
    int sz [NL];
    int layers;
    longint acc;
    out_item_t r;
    layers = sat(int'(regs[REG_LAYER_COUNT]), 2, NL);
    for (int l = 0; l < NL; l++) sz[l] = sat(int'(regs[REG_LAYER0_SIZE + l]), 1, NN);
    if (it.op == OP_WEIGHT) begin
      if (it.weight_layer < NL - 1 && it.weight_from <= NN)
        weights[it.weight_layer][it.weight_from][it.weight_to] = it.weight_value;
      return;
    end
    if (it.feature_index < sz[0]) acts[0][it.feature_index + 1] = it.feature_value;
    if (!it.last_feature) return;
    for (int l = 1; l < layers; l++) begin
      for (int n = 1; n <= sz[l]; n++) begin
        acc = 0;
        for (int j = 0; j <= sz[l-1]; j++)
          acc += longint'($signed(acts[l-1][j])) * longint'($signed(weights[l-1][j][n-1]));
        acts[l][n] = activation(acc);
      end
    end
    for (int n = 0; n < sz[layers-1]; n++) begin
      r.output_index = 4'(n);
      r.output_value = acts[layers-1][n+1][8:0];
      r.last_output  = (n == sz[layers-1] - 1);
      expected_results.push_back(r);
    end
    for (int j = 1; j < ND; j++) acts[0][j] = '0;
  endtask

  // Result checker: the receiver takes every strobed result.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        report("unexpected result", out_item, '0);
      end else begin
        if (out_item !== expected_results[0]) report("result", out_item, expected_results[0]);
        void'(expected_results.pop_front());
      end
    end
  end

  // Hold start high across back-to-back requests; drop it only before a pause.
  task automatic send(input in_item_t it);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start   <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_network(it);
    @(negedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (expected_results.size() != 0 || busy) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [4:0] v);
    logic [4:0] mask [6];
    mask = '{5'd7, 5'd31, 5'd31, 5'd31, 5'd31, 5'd1};
    start <= 1'b0;
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    regs[idx] = v & mask[idx];
  endtask

  function automatic in_item_t rand_item();
    logic [63:0] bits;
    bits = {$urandom, $urandom};
    return in_item_t'(bits[$bits(in_item_t)-1:0]);
  endfunction

  function automatic in_item_t weight_req(input int l, input int f, input int t,
                                          input logic [15:0] v);
    in_item_t it;
    it = rand_item();
    it.op = OP_WEIGHT; it.weight_layer = 2'(l); it.weight_from = 5'(f);
    it.weight_to = 4'(t); it.weight_value = v;
    return it;
  endfunction

  function automatic in_item_t feature_req(input int i, input logic [15:0] v, input bit last);
    in_item_t it;
    it = rand_item();
    it.op = OP_FEATURE; it.feature_index = 4'(i); it.feature_value = v;
    it.last_feature = last;
    return it;
  endfunction

  // Give a value to every weight the coming networks can read: the first
  // nl source layers, input-layer nodes up to f0, later nodes up to fn,
  // destinations below tn.
  task automatic load_weights(input int mode, input int nl, input int f0, input int fn,
                              input int tn);
    logic [15:0] v;
    for (int l = 0; l < nl; l++)
      for (int f = 0; f <= (l == 0 ? f0 : fn); f++)
        for (int t = 0; t < tn; t++) begin
          case (mode)
            0: v = 16'd0;
            1: v = 16'h7fff;
            default: v = 16'($urandom_range(0, 8191) - 4096);
          endcase
          send(weight_req(l, f, t, v));
        end
  endtask

  typedef struct {
    in_item_t   it;
    bit         has_exp;
    logic [8:0] exp_val;
  } stim_row_t;

  // Compare the result the predictor queued for a row with its typed-in value.
  task automatic check_row(input stim_row_t row);
    out_item_t got_r;
    out_item_t exp_r;
    if (row.has_exp && expected_results.size() != 0) begin
      got_r = expected_results[$];
      exp_r = got_r;
      exp_r.output_value = row.exp_val;
      if (got_r !== exp_r) report("directed row", got_r, exp_r);
    end
  endtask

  int sent_items = 0;

  initial begin
    stim_row_t rows [$];
    in_item_t it;
    int nf;
    for (int l = 0; l < NL; l++)
      for (int j = 0; j < ND; j++) acts[l][j] = j == 0 ? ONE_Q88 : 16'd0;
    regs = '{5'd3, 5'd4, 5'd4, 5'd1, 5'd1, 5'd1};
    build_sigmoid();
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // All weights zero: every sum is zero and the sigmoid gives one half.
    load_weights(0, 1, 4, 4, 1);
    write_reg(REG_LAYER_COUNT, 5'd2);
    write_reg(REG_LAYER1_SIZE, 5'd1);
    rows.push_back('{feature_req(0, 16'h7fff, 1'b1), 1'b1, 9'd128});
    rows.push_back('{feature_req(15, 16'h8000, 1'b1), 1'b1, 9'd128});
    foreach (rows[i]) begin
      send(rows[i].it);
      check_row(rows[i]);
    end
    drain();

    // Maximum weights and extreme features: saturation at both ends.
    load_weights(1, 1, 4, 4, 1);
    rows.delete();
    rows.push_back('{feature_req(0, 16'h7fff, 1'b1), 1'b1, 9'd256});
    rows.push_back('{feature_req(0, 16'h8000, 1'b1), 1'b1, 9'd0});
    rows.push_back('{feature_req(3, 16'h0100, 1'b0), 1'b0, 9'd0});
    rows.push_back('{feature_req(14, 16'h0100, 1'b1), 1'b0, 9'd0});
    rows.push_back('{weight_req(3, 0, 0, 16'hffff), 1'b0, 9'd0});
    rows.push_back('{weight_req(0, 17, 0, 16'hffff), 1'b0, 9'd0});
    rows.push_back('{weight_req(0, 31, 15, 16'h8000), 1'b0, 9'd0});
    foreach (rows[i]) begin
      send(rows[i].it);
      check_row(rows[i]);
    end
    drain();
    write_reg(REG_ACT_MODE, 5'd0);
    send(feature_req(0, 16'h7fff, 1'b1));
    drain();
    write_reg(REG_ACT_MODE, 5'd1);

    // Random weights, then random networks with mostly well-formed feature sets.
    load_weights(2, NL - 1, NN, HN, HN);
    drain();
    while (sent_items < 200) begin
      if (sent_items % 40 == 0) begin
        drain();
        write_reg(REG_LAYER_COUNT, 5'($urandom_range(0, 7)));
        write_reg(REG_LAYER0_SIZE, $urandom_range(0, 3) == 0 ? 5'd16 : 5'($urandom_range(0, 31)));
        write_reg(REG_LAYER1_SIZE, 5'($urandom_range(0, HN)));
        write_reg(REG_LAYER2_SIZE, 5'($urandom_range(0, HN)));
        write_reg(REG_LAYER3_SIZE, 5'($urandom_range(0, HN)));
        write_reg(REG_ACT_MODE, 5'($urandom_range(0, 5) != 0));
      end
      if ($urandom_range(0, 9) < 2) begin
        it = rand_item();
        if (it.op == OP_WEIGHT)
          it.weight_value = 16'($urandom_range(0, 8191) - 4096);
        send(it);
        sent_items++;
      end else begin
        nf = $urandom_range(1, 5);
        for (int k = 0; k < nf; k++) begin
          send(feature_req($urandom_range(0, 15), 16'($urandom), k == nf - 1));
          sent_items++;
        end
        if ($urandom_range(0, 7) == 0) drain();
      end
    end
    drain();
    if (errors == 0) begin
      $display("mlp_forward_inference_top: match");
    end else begin
      $display("mlp_forward_inference_top: mismatch");
    end
    $finish;
  end

  initial begin
    #(12 * 3000000);
    $display("mlp_forward_inference_top: mismatch");
    $finish;
  end

endmodule
